>>> rtl/core/whp_pkg.sv
// whp_pkg: shared types, constants and the tag lookup for the wav header parser
// no dependencies; imported by the result interface, the top level and the bench

package whp_pkg;

  // result status codes
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StTrunc     = 2'd1,
    StMalformed = 2'd2,
    StNonPcm    = 2'd3
  } status_e;

  localparam int unsigned PosW = 6;

  // byte positions of interest in the canonical header
  localparam logic [PosW-1:0] PosRiffEnd = 6'd3;
  localparam logic [PosW-1:0] PosWaveEnd = 6'd11;
  localparam logic [PosW-1:0] PosFmtEnd  = 6'd15;
  localparam logic [PosW-1:0] PosBitsEnd = 6'd35;
  localparam logic [PosW-1:0] PosDataEnd = 6'd39;
  localparam logic [PosW-1:0] PosLast    = 6'd43;

  localparam logic [31:0] FmtChunkSize = 32'd16;

  localparam int unsigned FrameW = 29;  // 16 bit channels times 13 bit bytes per sample
  localparam int unsigned DivCntW = 5;  // 32 quotient bits

  // expected tag character for a position: {is_tag, char}
  function automatic logic [8:0] tag_char(input logic [PosW-1:0] pos);
    logic [8:0] r;
    r = 9'h000;
    case (pos)
      6'd0:    r = {1'b1, 8'h52};  // R
      6'd1:    r = {1'b1, 8'h49};  // I
      6'd2:    r = {1'b1, 8'h46};  // F
      6'd3:    r = {1'b1, 8'h46};  // F
      6'd8:    r = {1'b1, 8'h57};  // W
      6'd9:    r = {1'b1, 8'h41};  // A
      6'd10:   r = {1'b1, 8'h56};  // V
      6'd11:   r = {1'b1, 8'h45};  // E
      6'd12:   r = {1'b1, 8'h66};  // f
      6'd13:   r = {1'b1, 8'h6d};  // m
      6'd14:   r = {1'b1, 8'h74};  // t
      6'd15:   r = {1'b1, 8'h20};  // space
      6'd36:   r = {1'b1, 8'h64};  // d
      6'd37:   r = {1'b1, 8'h61};  // a
      6'd38:   r = {1'b1, 8'h74};  // t
      6'd39:   r = {1'b1, 8'h61};  // a
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/whp_in_if.sv
// whp_in_if: byte stream channel into the wav header parser
// depends on nothing

interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

>>> rtl/core/whp_out_if.sv
// whp_out_if: result channel out of the wav header parser
// depends on whp_pkg for the status type

interface whp_out_if import whp_pkg::*; ;
  logic               valid;
  logic               ready;
  status_e            status;
  logic signed [31:0] riff_len;
  logic        [15:0] fmt_tag;
  logic        [15:0] chan_cnt;
  logic signed [31:0] samp_rate;
  logic signed [31:0] bytes_per_sec;
  logic        [15:0] frame_bytes;
  logic        [15:0] sample_bits;
  logic signed [31:0] frame_cnt;

  modport source (output valid, output status, output riff_len, output fmt_tag,
                  output chan_cnt, output samp_rate, output bytes_per_sec,
                  output frame_bytes, output sample_bits, output frame_cnt,
                  input ready);
  modport sink   (input valid, input status, input riff_len, input fmt_tag,
                  input chan_cnt, input samp_rate, input bytes_per_sec,
                  input frame_bytes, input sample_bits, input frame_cnt,
                  output ready);
endinterface

>>> rtl/core/wav_header_parser_top.sv
// wav_header_parser_top: canonical 44-byte riff/wave pcm header parser
// depends on whp_pkg, whp_in_if and whp_out_if

// Bytes of a file arrive one per beat; first_byte restarts the parse and last_byte marks
// the end of the stream. Header bytes 0 to 42 are taken at one beat per cycle while no
// result waits in the output register. One result beat is given per file: at the first
// failed check (bad tag, format chunk size not 16, stream ended early) or when byte 43
// completes the header; later bytes are dropped until the next first_byte. After byte
// 43 the input stalls through SFrame and SRate (one shared 32x32 multiplier forms the
// frame size and the expected byte rate), SCheck (the checks are judged), SDiv (a
// restoring divider with a single subtractor produces the sample count one quotient bit
// per cycle) and SFix (the sign is applied); when a rate, align or zero frame check fails
// the stall ends after SCheck. A result sits in an output register, and a byte is taken
// only when that register is empty or empties on the same edge, so a waiting result
// holds off the input. Fields other than status read zero unless ok.

module wav_header_parser_top import whp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  whp_in_if.sink    in_i,
  whp_out_if.source out_o
);

  // sequencer states
  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SFrame = 6'b000010,  // frame = channels * (bits >> 3)
    SRate  = 6'b000100,  // rate * frame, low 32 bits
    SCheck = 6'b001000,  // compare fields, load divider
    SDiv   = 6'b010000,  // one quotient bit per cycle
    SFix   = 6'b100000   // apply sign, emit result
  } state_e;

  state_e state_q, state_d;

  // parse control
  logic [PosW-1:0] pos_q;
  logic            finished_q;
  logic            tag_bad_q;

  // header fields, every lane written before it is read so no clear needed
  logic [31:0] riff_q, fmt_q, rate_q, byterate_q, data_q;
  logic [15:0] format_q, channels_q, align_q, bits_q;

  // shared arithmetic state
  logic [FrameW-1:0]  frame_q;
  logic [31:0]        rate_prod_q;
  logic [31:0]        rem_q, quo_q;
  logic               neg_q;
  logic [DivCntW-1:0] cnt_q;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [31:0]        out_chunk_q, out_rate_q, out_byterate_q, out_samples_q;
  logic [15:0]        out_format_q, out_channels_q, out_align_q, out_bits_q;

  // input side
  logic            in_fire, active;
  logic [PosW-1:0] pos_cur;
  logic            tag_bad_new;
  logic [8:0]      tag_exp;
  logic            emit;
  status_e         emit_status;
  logic            go_final;

  // the sequencer is idle and the output slot is free, or frees on this edge
  assign in_i.ready = (state_q == SIdle) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign active     = in_fire && (in_i.first_byte || !finished_q);
  assign pos_cur    = in_i.first_byte ? '0 : pos_q;
  assign tag_exp    = tag_char(pos_cur);
  assign tag_bad_new = (!in_i.first_byte && tag_bad_q) ||
                       (tag_exp[8] && (in_i.data_byte != tag_exp[7:0]));

  always_comb begin
    emit        = 1'b0;
    emit_status = StTrunc;
    go_final    = 1'b0;
    if (active) begin
      if (pos_cur == PosLast) begin
        go_final = 1'b1;
      end else if ((pos_cur == PosRiffEnd || pos_cur == PosWaveEnd ||
                    pos_cur == PosFmtEnd || pos_cur == PosDataEnd) && tag_bad_new) begin
        emit        = 1'b1;
        emit_status = StMalformed;
      end else if (pos_cur == PosBitsEnd && fmt_q != FmtChunkSize) begin
        emit        = 1'b1;
        emit_status = StNonPcm;
      end else if (in_i.last_byte) begin
        emit        = 1'b1;
        emit_status = StTrunc;
      end
    end
  end

  // shared multiplier, operands chosen by the sequencer
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    if (state_q == SFrame) begin
      mul_a = {16'h0000, channels_q};
      mul_b = {19'h00000, bits_q[15:3]};
    end else begin
      mul_a = rate_q;
      mul_b = {{(32-FrameW){1'b0}}, frame_q};
    end
  end
  assign mul_p = mul_a * mul_b;

  // divider step: shift in the next dividend bit, subtract if it fits
  logic [31:0] rem_sh;
  logic [32:0] diff;
  logic        fits;
  assign rem_sh = {rem_q[30:0], quo_q[31]};
  assign diff   = {1'b0, rem_sh} - {{(33-FrameW){1'b0}}, frame_q};
  assign fits   = !diff[32];

  logic check_bad;
  assign check_bad = (byterate_q != rate_prod_q) ||
                     ({{(FrameW-16){1'b0}}, align_q} != frame_q) ||
                     (frame_q == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (go_final) state_d = SFrame;
      SFrame:  state_d = SRate;
      SRate:   state_d = SCheck;
      SCheck:  state_d = check_bad ? SIdle : SDiv;
      SDiv:    if (cnt_q == '1) state_d = SFix;
      SFix:    state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pos_q       <= '0;
      finished_q  <= 1'b1;
      tag_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (active) begin
        tag_bad_q <= tag_bad_new;
        pos_q     <= pos_cur + 1'b1;
        // a result now, or one from the sequencer later
        finished_q <= emit || go_final;
      end
      if (state_q == SDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (emit || (state_q == SCheck && check_bad) || state_q == SFix) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // header capture, little-endian lanes
  always_ff @(posedge clk_i) begin
    if (active) begin
      if (pos_cur >= 6'd4 && pos_cur <= 6'd7)
        riff_q[8*pos_cur[1:0] +: 8] <= in_i.data_byte;
      if (pos_cur >= 6'd16 && pos_cur <= 6'd19)
        fmt_q[8*pos_cur[1:0] +: 8] <= in_i.data_byte;
      if (pos_cur == 6'd20 || pos_cur == 6'd21)
        format_q[8*pos_cur[0] +: 8] <= in_i.data_byte;
      if (pos_cur == 6'd22 || pos_cur == 6'd23)
        channels_q[8*pos_cur[0] +: 8] <= in_i.data_byte;
      if (pos_cur >= 6'd24 && pos_cur <= 6'd27)
        rate_q[8*pos_cur[1:0] +: 8] <= in_i.data_byte;
      if (pos_cur >= 6'd28 && pos_cur <= 6'd31)
        byterate_q[8*pos_cur[1:0] +: 8] <= in_i.data_byte;
      if (pos_cur == 6'd32 || pos_cur == 6'd33)
        align_q[8*pos_cur[0] +: 8] <= in_i.data_byte;
      if (pos_cur == 6'd34 || pos_cur == 6'd35)
        bits_q[8*pos_cur[0] +: 8] <= in_i.data_byte;
      if (pos_cur >= 6'd40 && pos_cur <= 6'd43)
        data_q[8*pos_cur[1:0] +: 8] <= in_i.data_byte;
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      SFrame: frame_q <= mul_p[FrameW-1:0];
      SRate:  rate_prod_q <= mul_p[31:0];
      SCheck: begin
        // divide the magnitude, sign restored at the end
        neg_q <= data_q[31];
        quo_q <= data_q[31] ? (32'd0 - data_q) : data_q;
        rem_q <= '0;
      end
      SDiv: begin
        rem_q <= fits ? diff[31:0] : rem_sh;
        quo_q <= {quo_q[30:0], fits};
      end
      default: ;
    endcase
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit || (state_q == SCheck && check_bad)) begin
      out_status_q   <= emit ? emit_status : StMalformed;
      out_chunk_q    <= '0;
      out_format_q   <= '0;
      out_channels_q <= '0;
      out_rate_q     <= '0;
      out_byterate_q <= '0;
      out_align_q    <= '0;
      out_bits_q     <= '0;
      out_samples_q  <= '0;
    end else if (state_q == SFix) begin
      out_status_q   <= StOk;
      out_chunk_q    <= riff_q;
      out_format_q   <= format_q;
      out_channels_q <= channels_q;
      out_rate_q     <= rate_q;
      out_byterate_q <= byterate_q;
      out_align_q    <= align_q;
      out_bits_q     <= bits_q;
      out_samples_q  <= neg_q ? (32'd0 - quo_q) : quo_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.riff_len      = out_chunk_q;
  assign out_o.fmt_tag       = out_format_q;
  assign out_o.chan_cnt      = out_channels_q;
  assign out_o.samp_rate     = out_rate_q;
  assign out_o.bytes_per_sec = out_byterate_q;
  assign out_o.frame_bytes   = out_align_q;
  assign out_o.sample_bits   = out_bits_q;
  assign out_o.frame_cnt     = out_samples_q;

endmodule

>>> dv/wav_header_parser_top_test.sv
// wav_header_parser_top_test: self-checking bench for the riff/wave header parser
// needs whp_pkg, whp_in_if, whp_out_if and wav_header_parser_top; nothing else

module wav_header_parser_top_test;
  import whp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no beat on either side
  localparam int unsigned HoldOffCycles = 400;   // long receiver stall, fills the block
  localparam int unsigned DrainCycles   = 60;    // division stall plus output register
  localparam int unsigned TotalBytes    = 1150;

  // one parse result as the block reports it
  typedef struct {
    status_e            status;
    logic signed [31:0] riff_len;
    logic        [15:0] fmt_tag;
    logic        [15:0] chan_cnt;
    logic signed [31:0] samp_rate;
    logic signed [31:0] bytes_per_sec;
    logic        [15:0] frame_bytes;
    logic        [15:0] sample_bits;
    logic signed [31:0] frame_cnt;
  } wav_result_t;

  // tracks the parse byte by byte and holds the results that are still owed
  class header_checker;
    logic [5:0]  byte_pos;
    bit          done;
    bit          tag_bad;
    logic [31:0] riff_size, fmt_size, rate, hdr_brate, data_size;
    logic [15:0] fmt_code, chans, align, bits;
    wav_result_t due_results[$];
    int unsigned failures;

    function new();
      failures = 0;
      clear();
      done = 1'b1;
    endfunction

    function void clear();
      byte_pos  = '0;
      tag_bad   = 1'b0;
      riff_size = '0;
      fmt_size  = '0;
      rate      = '0;
      hdr_brate = '0;
      data_size = '0;
      fmt_code  = '0;
      chans     = '0;
      align     = '0;
      bits      = '0;
    endfunction

    // tag character owed at a position, if any
    function bit tag_at(input logic [5:0] p, output logic [7:0] c);
      string tags;
      int    idx;
      tags = "RIFFWAVEfmt data";
      idx  = -1;
      c    = 8'h00;
      if (p <= 6'd3) idx = p;
      else if (p >= 6'd8 && p <= 6'd15) idx = p - 4;
      else if (p >= 6'd36 && p <= 6'd39) idx = p - 24;
      if (idx < 0) return 1'b0;
      c = tags[idx];
      return 1'b1;
    endfunction

    // little-endian field capture
    function void store(input logic [5:0] p, input logic [7:0] b);
      if (p >= 6'd4 && p <= 6'd7) riff_size[(p-4)*8 +: 8] = b;
      else if (p >= 6'd16 && p <= 6'd19) fmt_size[(p-16)*8 +: 8] = b;
      else if (p >= 6'd20 && p <= 6'd21) fmt_code[(p-20)*8 +: 8] = b;
      else if (p >= 6'd22 && p <= 6'd23) chans[(p-22)*8 +: 8] = b;
      else if (p >= 6'd24 && p <= 6'd27) rate[(p-24)*8 +: 8] = b;
      else if (p >= 6'd28 && p <= 6'd31) hdr_brate[(p-28)*8 +: 8] = b;
      else if (p >= 6'd32 && p <= 6'd33) align[(p-32)*8 +: 8] = b;
      else if (p >= 6'd34 && p <= 6'd35) bits[(p-34)*8 +: 8] = b;
      else if (p >= 6'd40 && p <= 6'd43) data_size[(p-40)*8 +: 8] = b;
    endfunction

    function void take_byte(input logic [7:0] b, input logic f, input logic l);
      logic [7:0]  c;
      logic [31:0] frame;
      logic [31:0] rate_prod;
      longint      quot;
      bit          have;
      status_e     st;
      wav_result_t r;
      if (f) begin
        clear();
        done = 1'b0;
      end else if (done) begin
        return;
      end
      if (tag_at(byte_pos, c) && b !== c) tag_bad = 1'b1;
      store(byte_pos, b);
      have = 1'b0;
      st   = StOk;
      quot = 0;
      if ((byte_pos == PosRiffEnd || byte_pos == PosWaveEnd || byte_pos == PosFmtEnd ||
           byte_pos == PosDataEnd) && tag_bad) begin
        have = 1'b1;
        st   = StMalformed;
      end
      if (byte_pos == PosBitsEnd && fmt_size != FmtChunkSize) begin
        have = 1'b1;
        st   = StNonPcm;
      end
      if (byte_pos >= PosLast) begin
        have      = 1'b1;
        frame     = {16'h0, chans} * {19'h0, bits[15:3]};
        rate_prod = rate * frame;
        if (hdr_brate != rate_prod || {16'h0, align} != frame || frame == 32'd0) begin
          st = StMalformed;
        end else begin
          st   = StOk;
          quot = longint'($signed(data_size)) / longint'(frame);
        end
      end
      if (!have && l) begin
        have = 1'b1;
        st   = StTrunc;
      end
      if (!have) begin
        byte_pos = byte_pos + 6'd1;
        return;
      end
      done = 1'b1;
      r = '{status: st, default: '0};
      if (st == StOk) begin
        r.riff_len      = riff_size;
        r.fmt_tag       = fmt_code;
        r.chan_cnt      = chans;
        r.samp_rate     = rate;
        r.bytes_per_sec = hdr_brate;
        r.frame_bytes   = align;
        r.sample_bits   = bits;
        r.frame_cnt     = quot[31:0];
      end
      due_results.push_back(r);
    endfunction

    function void cmp(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
        failures++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      end
    endfunction

    function void match_result(input wav_result_t got);
      wav_result_t e;
      if (due_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result beat, status expected none, got %0d",
                 $time, got.status);
        return;
      end
      e = due_results.pop_front();
      cmp("status", 32'(e.status), 32'(got.status));
      cmp("riff_len", e.riff_len, got.riff_len);
      cmp("fmt_tag", 32'(e.fmt_tag), 32'(got.fmt_tag));
      cmp("chan_cnt", 32'(e.chan_cnt), 32'(got.chan_cnt));
      cmp("samp_rate", e.samp_rate, got.samp_rate);
      cmp("bytes_per_sec", e.bytes_per_sec, got.bytes_per_sec);
      cmp("frame_bytes", 32'(e.frame_bytes), 32'(got.frame_bytes));
      cmp("sample_bits", 32'(e.sample_bits), 32'(got.sample_bits));
      cmp("frame_cnt", e.frame_cnt, got.frame_cnt);
    endfunction

    function int owed();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  whp_in_if  in_if ();
  whp_out_if out_if ();

  wav_header_parser_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  header_checker sb = new();

  bit          quiet_in;      // no sender gaps for the current file
  bit          quiet_out;     // receiver always ready for the current file
  bit          hold_off_req;  // asks the receiver for one long stall
  int unsigned idle_cycles;
  int unsigned sent_bytes;
  wav_result_t seen_result;

  // 12 unit period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, plus the long hold-off when asked for
  initial begin
    int low_left;
    low_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        low_left     = HoldOffCycles;
      end
      if (low_left > 0) begin
        out_if.ready <= 1'b0;
        low_left--;
      end else if (!quiet_out && $urandom_range(0, 99) < 18) begin
        low_left      = pick_gap() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // sampling at the rising edge: result check first, then the new byte, then the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen_result.status        = out_if.status;
        seen_result.riff_len      = out_if.riff_len;
        seen_result.fmt_tag       = out_if.fmt_tag;
        seen_result.chan_cnt      = out_if.chan_cnt;
        seen_result.samp_rate     = out_if.samp_rate;
        seen_result.bytes_per_sec = out_if.bytes_per_sec;
        seen_result.frame_bytes   = out_if.frame_bytes;
        seen_result.sample_bits   = out_if.sample_bits;
        seen_result.frame_cnt     = out_if.frame_cnt;
        sb.match_result(seen_result);
      end
      if (in_if.valid && in_if.ready) begin
        sb.take_byte(in_if.data_byte, in_if.first_byte, in_if.last_byte);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // one byte beat, with an optional gap before it; returns once accepted
  task automatic send_byte(input logic [7:0] b, input bit f, input bit l);
    int gap;
    gap = (quiet_in || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.first_byte <= f;
    in_if.last_byte  <= l;
    do @(posedge clk); while (!in_if.ready);
    sent_bytes++;
  endtask

  // random bytes, mostly without first_byte; after a result, dropped until a first_byte
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  // builds a canonical header with consistent rates, flips one byte if asked,
  // sends the first len bytes and then trail bytes of sample data
  task automatic send_header(input logic [31:0] riff, input logic [15:0] fmt_code,
                             input logic [15:0] chans, input logic [15:0] bits,
                             input logic [31:0] rate, input logic [31:0] dsize,
                             input int bad_pos, input logic [7:0] bad_xor,
                             input int len, input bit end_stream, input int trail);
    logic [7:0]  h [44];
    logic [31:0] frame;
    logic [31:0] brate;
    string       tag_text;
    tag_text = "RIFFWAVEfmt data";
    frame    = {16'h0, chans} * {19'h0, bits[15:3]};
    brate    = rate * frame;
    for (int k = 0; k < 4; k++) begin
      h[k]      = tag_text[k];
      h[8 + k]  = tag_text[4 + k];
      h[12 + k] = tag_text[8 + k];
      h[36 + k] = tag_text[12 + k];
    end
    {h[7], h[6], h[5], h[4]}     = riff;
    {h[19], h[18], h[17], h[16]} = FmtChunkSize;
    {h[21], h[20]}               = fmt_code;
    {h[23], h[22]}               = chans;
    {h[27], h[26], h[25], h[24]} = rate;
    {h[31], h[30], h[29], h[28]} = brate;
    {h[33], h[32]}               = frame[15:0];
    {h[35], h[34]}               = bits;
    {h[43], h[42], h[41], h[40]} = dsize;
    if (bad_pos >= 0) h[bad_pos] = h[bad_pos] ^ bad_xor;
    for (int i = 0; i < len; i++) begin
      send_byte(h[i], i == 0, end_stream && trail == 0 && i == len - 1);
    end
    for (int t = 0; t < trail; t++) begin
      send_byte(8'($urandom), 1'b0, end_stream && t == trail - 1);
    end
  endtask

  // sender pause: nothing offered until every owed result is back, then the stall time
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.owed() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // one random file: mostly well-formed headers, some with a broken field or cut short
  task automatic send_random_file();
    logic [15:0] chans, bits, fmt_code;
    logic [31:0] rate;
    int          mut, bad_pos, len, trail, idx;
    logic [7:0]  bad_xor;
    bit          end_s;
    case ($urandom_range(0, 9))
      0, 1:    chans = 16'($urandom_range(0, 65535));
      2:       chans = 16'd0;
      default: chans = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: bits = 16'($urandom_range(0, 65535));
      3:       bits = 16'hFFFF;
      default: bits = 16'(8 * $urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 7))
      0:       rate = 32'd8000;
      1:       rate = 32'd44100;
      2:       rate = 32'd48000;
      3:       rate = 32'd96000;
      default: rate = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       fmt_code = 16'd3;
      1:       fmt_code = 16'($urandom);
      default: fmt_code = 16'd1;
    endcase
    mut     = $urandom_range(0, 99);
    bad_pos = -1;
    bad_xor = 8'($urandom_range(1, 255));
    len     = 44;
    end_s   = $urandom_range(0, 3) == 0;
    trail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (mut < 55) begin
      // well-formed
    end else if (mut < 63) begin
      idx     = $urandom_range(0, 15);
      bad_pos = (idx < 4) ? idx : (idx < 12) ? idx + 4 : idx + 24;
    end else if (mut < 70) begin
      bad_pos = $urandom_range(16, 19);
    end else if (mut < 78) begin
      bad_pos = $urandom_range(28, 33);
    end else if (mut < 88) begin
      len   = $urandom_range(1, 43);
      end_s = 1'b1;
      trail = 0;
    end else if (mut < 94) begin
      // a parse dropped by a fresh first_byte
      send_header($urandom, fmt_code, chans, bits, rate, $urandom, -1, 8'h00,
                  $urandom_range(1, 43), 1'b0, 0);
    end else begin
      bits = 16'($urandom_range(0, 7));
    end
    send_header($urandom, fmt_code, chans, bits, rate, $urandom, bad_pos, bad_xor,
                len, end_s, trail);
    if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 5));
  endtask

  initial begin
    int nfile;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    quiet_in         = 1'b0;
    quiet_out        = 1'b0;
    hold_off_req     = 1'b0;
    idle_cycles      = 0;
    sent_bytes       = 0;
    rst_n            = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: bytes before any first_byte are dropped
    send_noise(3);
    // plain stereo 16 bit
    send_header(32'd1036, 16'd1, 16'd2, 16'd16, 32'd44100, 32'd1000, -1, 8'h00, 44, 0, 0);
    // widest frame, all-ones fields, most negative data size, last_byte on byte 43
    send_header('1, 16'hFFFF, 16'hFFFF, 16'd8, '1, 32'h8000_0000, -1, 8'h00, 44, 1, 0);
    // widest sample, zero rate, largest data size, sample data after the header
    send_header(32'd0, 16'd3, 16'd1, 16'hFFFF, 32'd0, 32'h7FFF_FFFF, -1, 8'h00, 44, 1, 3);
    // a bad character in each tag
    send_header(32'd36, 16'd1, 16'd1, 16'd8, 32'd8000, 32'd0, 0, 8'h01, 44, 0, 0);
    send_header(32'd36, 16'd1, 16'd1, 16'd8, 32'd8000, 32'd0, 9, 8'h80, 44, 0, 0);
    send_header(32'd36, 16'd1, 16'd1, 16'd8, 32'd8000, 32'd0, 15, 8'hFF, 44, 0, 0);
    send_header(32'd36, 16'd1, 16'd1, 16'd8, 32'd8000, 32'd0, 38, 8'h20, 44, 0, 0);
    // format chunk size 18
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, 16, 8'h02, 44, 0, 0);
    // byte rate off by one, then block align off
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, 28, 8'h01, 44, 0, 0);
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, 33, 8'h01, 44, 0, 0);
    // zero frame from sub-byte samples, then from zero channels
    send_header(32'd36, 16'd1, 16'd2, 16'd7, 32'd48000, 32'd64, -1, 8'h00, 44, 0, 0);
    send_header(32'd36, 16'd1, 16'd0, 16'd16, 32'd48000, 32'd64, -1, 8'h00, 44, 0, 0);
    // stream ends early, mid field
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, -1, 8'h00, 21, 1, 0);
    // stream ends on the last byte of a bad tag: the tag error wins
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, 1, 8'h04, 4, 1, 0);
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, 10, 8'h10, 12, 1, 0);
    // stream ends on byte 35 with a good format size: truncated
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, -1, 8'h00, 36, 1, 0);
    // one byte that is both first and last
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, -1, 8'h00, 1, 1, 0);
    // restart mid-parse, then negative data size truncating toward zero
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd48000, 32'd64, -1, 8'h00, 30, 0, 0);
    send_header(32'd36, 16'd1, 16'd2, 16'd16, 32'd22050, 32'hFFFF_FFF9, -1, 8'h00, 44, 0, 0);
    send_noise(4);
    drain_results();

    // random part, up to the byte budget
    nfile = 0;
    while (sent_bytes < TotalBytes) begin
      quiet_in  = $urandom_range(0, 9) == 0;
      quiet_out = $urandom_range(0, 9) == 0;
      // long receiver stall while the sender keeps going, so the input backs up
      if (nfile == 1) begin
        quiet_in     = 1'b1;
        hold_off_req = 1'b1;
      end
      if (nfile == 4) drain_results();
      send_random_file();
      nfile++;
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    drain_results();

    if (sb.failures == 0 && sb.owed() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.owed() != 0) $display("%0t: %0d results never arrived", $time, sb.owed());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/whp_pkg.sv
rtl/core/whp_in_if.sv
rtl/core/whp_out_if.sv
rtl/core/wav_header_parser_top.sv
dv/wav_header_parser_top_test.sv
